/* rtl/ttuc_pkg.sv */
// Shared types, opcode codes and constants of the tick / time-unit converter.
// Depends on nothing; every other file of the block uses it by scoped names.
package ttuc_pkg;

   localparam int DATA_W      = 64;
   localparam int RATE_W      = 34;
   localparam int SUB_W       = 20;
   localparam int FRAC_W      = 30;
   localparam int OP_W        = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [OP_W-1:0] OP_S2T      = 4'd0;
   localparam logic [OP_W-1:0] OP_MS2T     = 4'd1;
   localparam logic [OP_W-1:0] OP_US2T     = 4'd2;
   localparam logic [OP_W-1:0] OP_NS2T     = 4'd3;
   localparam logic [OP_W-1:0] OP_T2S      = 4'd4;
   localparam logic [OP_W-1:0] OP_T2MS     = 4'd5;
   localparam logic [OP_W-1:0] OP_T2US     = 4'd6;
   localparam logic [OP_W-1:0] OP_T2NS     = 4'd7;
   localparam logic [OP_W-1:0] OP_SPLIT_NS = 4'd8;
   localparam logic [OP_W-1:0] OP_SPLIT_US = 4'd9;
   localparam logic [OP_W-1:0] OP_SUS2T    = 4'd10;
   localparam logic [OP_W-1:0] OP_RATE     = 4'd11;

   localparam logic [DATA_W-1:0] ALL_ONES   = '1;
   localparam logic [RATE_W-1:0] RATE_RESET = 34'd2000000000;

   localparam logic [FRAC_W-1:0] NS_PER_S = 30'd1000000000;
   localparam logic [FRAC_W-1:0] US_PER_S = 30'd1000000;
   localparam logic [FRAC_W-1:0] MS_PER_S = 30'd1000;

   // ticks -> unit: below these the product t * scale stays within 64 bits
   localparam logic [DATA_W-1:0] LIM_MS = ALL_ONES / 64'd1000;
   localparam logic [DATA_W-1:0] LIM_US = ALL_ONES / 64'd1000000;
   localparam logic [DATA_W-1:0] LIM_NS = ALL_ONES / 64'd1000000000;

   // unit or scale that goes with an opcode
   function automatic logic [FRAC_W-1:0] unit_of(logic [OP_W-1:0] op);
      logic [FRAC_W-1:0] u;
      u = 30'd1;
      case (op)
         OP_MS2T, OP_T2MS:              u = MS_PER_S;
         OP_US2T, OP_T2US, OP_SPLIT_US: u = US_PER_S;
         OP_NS2T, OP_T2NS, OP_SPLIT_NS: u = NS_PER_S;
         default:                       u = 30'd1;
      endcase
      return u;
   endfunction

   // side data that travels with an item through the dividers
   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [DATA_W-1:0] amount;
      logic              mul_first;
      logic [DATA_W-1:0] sec;
      logic              dz;
   } tag_type;

   // item held in the queue between front and back
   typedef struct packed {
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
      tag_type           tag;
   } qitem_type;

endpackage

/* rtl/ttuc_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, 64 stages.
// Depends on ttuc_pkg for widths and the side-data type.
module ttuc_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [ttuc_pkg::DATA_W-1:0] in_num,
   input  logic [ttuc_pkg::DATA_W-1:0] in_den,
   input  ttuc_pkg::tag_type           in_tag,
   output logic                        out_valid,
   output logic [ttuc_pkg::DATA_W-1:0] out_quo,
   output ttuc_pkg::tag_type           out_tag
);

   localparam int W = ttuc_pkg::DATA_W;

   logic              valid_ff [W];
   logic              valid_in [W];
   logic              zero_ff  [W];
   logic              zero_in  [W];
   logic [W-1:0]      rem_ff   [W];
   logic [W-1:0]      rem_in   [W];
   logic [W-1:0]      nq_ff    [W];
   logic [W-1:0]      nq_in    [W];
   logic [W-1:0]      den_ff   [W];
   logic [W-1:0]      den_in   [W];
   ttuc_pkg::tag_type tag_ff   [W];
   ttuc_pkg::tag_type tag_in   [W];

   for (genvar i = 0; i < W; i++) begin : g_stage
      logic              v_src;
      logic              z_src;
      logic [W-1:0]      rem_src;
      logic [W-1:0]      nq_src;
      logic [W-1:0]      den_src;
      ttuc_pkg::tag_type tag_src;
      logic [W:0]        trial;
      logic [W:0]        diff;
      logic              ge;

      if (i == 0) begin : g_first
         assign v_src   = in_valid;
         assign z_src   = (in_den == '0);
         assign rem_src = '0;
         assign nq_src  = in_num;
         assign den_src = in_den;
         assign tag_src = in_tag;
      end else begin : g_next
         assign v_src   = valid_ff[i-1];
         assign z_src   = zero_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign nq_src  = nq_ff[i-1];
         assign den_src = den_ff[i-1];
         assign tag_src = tag_ff[i-1];
      end

      // shift in the next dividend bit, subtract when the divisor fits
      assign trial = {rem_src, nq_src[W-1]};
      assign diff  = trial - {1'b0, den_src};
      assign ge    = (trial >= {1'b0, den_src});

      assign valid_in[i] = v_src;
      assign zero_in[i]  = z_src;
      assign rem_in[i]   = ge ? diff[W-1:0] : trial[W-1:0];
      assign nq_in[i]    = {nq_src[W-2:0], ge};
      assign den_in[i]   = den_src;
      assign tag_in[i]   = tag_src;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '{default: 1'b0};
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         zero_ff <= zero_in;
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         den_ff  <= den_in;
         tag_ff  <= tag_in;
      end
   end

   // zero divisor gives zero
   assign out_valid = valid_ff[W-1];
   assign out_quo   = zero_ff[W-1] ? '0 : nq_ff[W-1];
   assign out_tag   = tag_ff[W-1];

endmodule

/* rtl/ttuc_front.sv */
// Front part: decodes the opcode, forms products, runs the first division
// and prepares the operands of the second. Depends on ttuc_pkg, ttuc_divider.
module ttuc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ttuc_pkg::RATE_W-1:0] hz,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [ttuc_pkg::OP_W-1:0]   opcode,
   input  logic [ttuc_pkg::DATA_W-1:0] amount,
   input  logic [ttuc_pkg::SUB_W-1:0]  sub_second,
   output logic                        out_valid,
   input  logic                        out_ready,
   output ttuc_pkg::qitem_type         out_item
);

   logic en;

   // decode
   logic [64:0]                 mul_a;
   logic [33:0]                 mul_b;
   logic                        small_t;

   logic                        f1_valid_ff;
   logic [65:0]                 f1_lo_ff;
   logic [66:0]                 f1_hi_ff;
   logic [ttuc_pkg::OP_W-1:0]   f1_op_ff;
   logic [ttuc_pkg::DATA_W-1:0] f1_amount_ff;
   logic                        f1_small_ff;

   logic [98:0]                 prod1;
   logic                        fits;
   logic [63:0]                 hz64;
   logic [63:0]                 n1;
   logic [63:0]                 d1;
   ttuc_pkg::tag_type           tag1;

   logic                        q1_valid;
   logic [63:0]                 q1;
   ttuc_pkg::tag_type           q1_tag;

   logic                        m1_valid_ff;
   logic [65:0]                 m1_lo_ff;
   logic [65:0]                 m1_hi_ff;
   logic [63:0]                 m1_quo_ff;
   ttuc_pkg::tag_type           m1_tag_ff;
   logic [63:0]                 mul2_a;

   logic [63:0]                 prod2;
   logic [63:0]                 rem;
   logic [63:0]                 n2;
   logic [63:0]                 d2;
   ttuc_pkg::tag_type           tag2;

   logic                        m2_valid_ff;
   logic [63:0]                 m2_num_ff;
   logic [63:0]                 m2_den_ff;
   logic [33:0]                 m2_rem_ff;
   ttuc_pkg::tag_type           m2_tag_ff;
   logic                        split;
   logic [63:0]                 frac_num;

   assign en       = !m2_valid_ff || out_ready;
   assign in_ready = en;
   assign hz64     = {30'd0, hz};

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      small_t = 1'b0;
      unique case (opcode) inside
         ttuc_pkg::OP_S2T, ttuc_pkg::OP_MS2T, ttuc_pkg::OP_US2T, ttuc_pkg::OP_NS2T: begin
            // (amount + 1) * hz fits exactly when amount < all_ones / hz
            mul_a = {1'b0, amount} + 65'd1;
            mul_b = hz;
         end
         ttuc_pkg::OP_T2MS: begin
            mul_a   = {1'b0, amount};
            mul_b   = {4'd0, ttuc_pkg::MS_PER_S};
            small_t = amount < ttuc_pkg::LIM_MS;
         end
         ttuc_pkg::OP_T2US: begin
            mul_a   = {1'b0, amount};
            mul_b   = {4'd0, ttuc_pkg::US_PER_S};
            small_t = amount < ttuc_pkg::LIM_US;
         end
         ttuc_pkg::OP_T2NS: begin
            mul_a   = {1'b0, amount};
            mul_b   = {4'd0, ttuc_pkg::NS_PER_S};
            small_t = amount < ttuc_pkg::LIM_NS;
         end
         ttuc_pkg::OP_SUS2T: begin
            mul_a = {45'd0, sub_second};
            mul_b = hz;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= in_valid;
      end
      if (en) begin
         f1_lo_ff     <= mul_a[31:0] * mul_b;
         f1_hi_ff     <= mul_a[64:32] * mul_b;
         f1_op_ff     <= opcode;
         f1_amount_ff <= amount;
         f1_small_ff  <= small_t;
      end
   end

   assign prod1 = {33'd0, f1_lo_ff} + {f1_hi_ff, 32'd0};
   assign fits  = (hz != '0) && (prod1[98:64] == '0);

   always_comb begin
      n1          = '0;
      d1          = 64'd1;
      tag1        = '0;
      tag1.opcode = f1_op_ff;
      tag1.amount = f1_amount_ff;
      unique case (f1_op_ff) inside
         ttuc_pkg::OP_S2T: begin
            tag1.mul_first = fits;
            n1             = fits ? prod1[63:0] - hz64 : ttuc_pkg::ALL_ONES;
         end
         ttuc_pkg::OP_MS2T, ttuc_pkg::OP_US2T, ttuc_pkg::OP_NS2T: begin
            // multiply first when it fits, else divide first
            tag1.mul_first = fits;
            n1             = fits ? prod1[63:0] - hz64 : f1_amount_ff;
            d1             = {34'd0, ttuc_pkg::unit_of(f1_op_ff)};
         end
         ttuc_pkg::OP_T2S, ttuc_pkg::OP_SPLIT_NS, ttuc_pkg::OP_SPLIT_US: begin
            n1 = f1_amount_ff;
            d1 = hz64;
         end
         ttuc_pkg::OP_T2MS, ttuc_pkg::OP_T2US, ttuc_pkg::OP_T2NS: begin
            tag1.mul_first = f1_small_ff;
            if (f1_small_ff) begin
               n1 = prod1[63:0];
               d1 = hz64;
            end else begin
               // large: first hz / scale, then ticks / that
               n1 = hz64;
               d1 = {34'd0, ttuc_pkg::unit_of(f1_op_ff)};
            end
         end
         ttuc_pkg::OP_SUS2T: begin
            n1 = prod1[63:0];
            d1 = {34'd0, ttuc_pkg::US_PER_S};
         end
         ttuc_pkg::OP_RATE: begin
            n1 = hz64;
            d1 = f1_amount_ff;
         end
         default: ;
      endcase
   end

   ttuc_divider u_div1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f1_valid_ff),
      .in_num    (n1),
      .in_den    (d1),
      .in_tag    (tag1),
      .out_valid (q1_valid),
      .out_quo   (q1),
      .out_tag   (q1_tag)
   );

   assign mul2_a = (q1_tag.opcode == ttuc_pkg::OP_SUS2T) ? q1_tag.amount : q1;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= q1_valid;
      end
      if (en) begin
         m1_lo_ff  <= mul2_a[31:0] * hz;
         m1_hi_ff  <= mul2_a[63:32] * hz;
         m1_quo_ff <= q1;
         m1_tag_ff <= q1_tag;
      end
   end

   // low 64 bits of the product, wraps
   assign prod2 = m1_lo_ff[63:0] + {m1_hi_ff[31:0], 32'd0};
   assign rem   = m1_tag_ff.amount - prod2;

   always_comb begin
      n2       = m1_quo_ff;
      d2       = 64'd1;
      tag2     = m1_tag_ff;
      tag2.sec = m1_quo_ff;
      tag2.dz  = (m1_tag_ff.opcode == ttuc_pkg::OP_RATE) && (m1_tag_ff.amount == '0);
      unique case (m1_tag_ff.opcode) inside
         ttuc_pkg::OP_MS2T, ttuc_pkg::OP_US2T, ttuc_pkg::OP_NS2T: begin
            n2 = m1_tag_ff.mul_first ? m1_quo_ff : prod2;
         end
         ttuc_pkg::OP_T2MS, ttuc_pkg::OP_T2US, ttuc_pkg::OP_T2NS: begin
            if (!m1_tag_ff.mul_first) begin
               n2 = m1_tag_ff.amount;
               d2 = m1_quo_ff;
            end
         end
         ttuc_pkg::OP_SPLIT_NS, ttuc_pkg::OP_SPLIT_US: begin
            d2 = hz64;
         end
         ttuc_pkg::OP_SUS2T: begin
            n2 = prod2 + m1_quo_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m2_valid_ff <= m1_valid_ff;
      end
      if (en) begin
         m2_num_ff <= n2;
         m2_den_ff <= d2;
         m2_rem_ff <= rem[33:0];
         m2_tag_ff <= tag2;
      end
   end

   // remainder below hz, so 34 bits carry it
   assign split    = (m2_tag_ff.opcode == ttuc_pkg::OP_SPLIT_NS) ||
                     (m2_tag_ff.opcode == ttuc_pkg::OP_SPLIT_US);
   assign frac_num = {30'd0, m2_rem_ff} * {34'd0, ttuc_pkg::unit_of(m2_tag_ff.opcode)};

   assign out_valid    = m2_valid_ff;
   assign out_item.num = split ? frac_num : m2_num_ff;
   assign out_item.den = m2_den_ff;
   assign out_item.tag = m2_tag_ff;

endmodule

/* rtl/ttuc_queue.sv */
// Short queue between front and back parts.
// Depends on ttuc_pkg for the item type.
module ttuc_queue #(
   parameter int DEPTH = ttuc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ttuc_pkg::qitem_type in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output ttuc_pkg::qitem_type out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ttuc_pkg::qitem_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                push;
   logic                pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

/* rtl/ttuc_back.sv */
// Back part: second division and result register.
// Depends on ttuc_pkg and ttuc_divider.
module ttuc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  ttuc_pkg::qitem_type         in_item,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [ttuc_pkg::DATA_W-1:0] whole,
   output logic [ttuc_pkg::FRAC_W-1:0] fraction,
   output logic                        divide_by_zero
);

   logic                        en;
   logic                        q2_valid;
   logic [63:0]                 q2;
   ttuc_pkg::tag_type           q2_tag;
   logic                        split;

   logic                        out_valid_ff;
   logic [ttuc_pkg::DATA_W-1:0] whole_ff;
   logic [ttuc_pkg::FRAC_W-1:0] fraction_ff;
   logic                        dz_ff;

   assign en       = !out_valid_ff || out_ready;
   assign in_ready = en;

   ttuc_divider u_div2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid),
      .in_num    (in_item.num),
      .in_den    (in_item.den),
      .in_tag    (in_item.tag),
      .out_valid (q2_valid),
      .out_quo   (q2),
      .out_tag   (q2_tag)
   );

   assign split = (q2_tag.opcode == ttuc_pkg::OP_SPLIT_NS) ||
                  (q2_tag.opcode == ttuc_pkg::OP_SPLIT_US);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= q2_valid;
      end
      if (en) begin
         whole_ff    <= split ? q2_tag.sec : q2;
         fraction_ff <= split ? q2[ttuc_pkg::FRAC_W-1:0] : '0;
         dz_ff       <= q2_tag.dz;
      end
   end

   assign out_valid      = out_valid_ff;
   assign whole          = whole_ff;
   assign fraction       = fraction_ff;
   assign divide_by_zero = dz_ff;

endmodule

/* rtl/tick_time_unit_converter.sv */
// Top level of the tick / time-unit converter.
// Depends on ttuc_pkg, ttuc_front, ttuc_queue and ttuc_back.
//
// Converts between tick counts of a counter at tick_rate_hz and seconds,
// ms, us or ns, splits ticks into seconds plus a fraction, and turns a rate
// into a period. One item in, one item out, in order. The block takes one
// item per clock until the queue fills; items pass the two 64-stage pipelined
// dividers (front and back), the multiply stages and the queue between them.
// The front keeps accepting while a result waits at rsp; it stalls only once
// the queue (QUEUE_DEPTH items) is full. The user must write the rate register
// over csr_* only while no item is in flight; the block does not enforce it.
module tick_time_unit_converter #(
   parameter int QUEUE_DEPTH = ttuc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = amount[63:0], sub_second[83:64], zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,
   // tuser = opcode[3:0]
   input  logic [3:0]  req_tuser,
   // response: tdata = whole[63:0], fraction[93:64], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,
   // tuser = divide_by_zero[0]
   output logic [0:0]  rsp_tuser,
   // rate register write: tdata = tick_rate_hz[33:0], zero pad
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [39:0] csr_tdata
);

   logic [ttuc_pkg::RATE_W-1:0] hz_ff;

   logic                        fq_valid;
   logic                        fq_ready;
   ttuc_pkg::qitem_type         fq_item;
   logic                        qb_valid;
   logic                        qb_ready;
   ttuc_pkg::qitem_type         qb_item;

   logic [ttuc_pkg::DATA_W-1:0] whole;
   logic [ttuc_pkg::FRAC_W-1:0] fraction;
   logic                        dz;

   // rate register, always ready
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hz_ff <= ttuc_pkg::RATE_RESET;
      end else if (csr_tvalid) begin
         hz_ff <= csr_tdata[ttuc_pkg::RATE_W-1:0];
      end
   end

   ttuc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .hz         (hz_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .opcode     (req_tuser),
      .amount     (req_tdata[63:0]),
      .sub_second (req_tdata[83:64]),
      .out_valid  (fq_valid),
      .out_ready  (fq_ready),
      .out_item   (fq_item)
   );

   ttuc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   ttuc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (qb_valid),
      .in_ready       (qb_ready),
      .in_item        (qb_item),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .whole          (whole),
      .fraction       (fraction),
      .divide_by_zero (dz)
   );

   assign rsp_tdata = {2'b00, fraction, whole};
   assign rsp_tuser = dz;

endmodule
